// ===== rtl/srms_pkg.sv =====
package srms_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned FRAME_W   = 9;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_FRAME_PAIRS_DEF = 256;

  localparam logic [FRAME_W-1:0] FRAME_PAIRS_RST = 9'd128;
  localparam logic [LEVEL_W-1:0] WEIGHT_RST      = 16'd4588;
  localparam logic [LEVEL_W-1:0] FULL_SCALE_RST  = 16'd11141;

  localparam int unsigned SMOOTH_W  = 24;
  localparam int unsigned ACC_W     = 42;
  localparam int unsigned ROOT_W    = 16;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned MUL_A_W   = 25;
  localparam int unsigned MUL_B_W   = 18;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PAIRS  = 2'd0,
    REG_SMOOTH_WEIGHT = 2'd1,
    REG_FULL_SCALE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ1,
    S_SQ2,
    S_DIV,
    S_SQRT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SCL0,
    S_SCL,
    S_OUT
  } srms_state_t;

endpackage

// ===== rtl/smoothed_rms_audio_level_unit.sv =====
// A pair that does not close a frame passes S_SQ1 and S_SQ2, stall high after acceptance.
// A frame-closing pair shows its word once the bit-serial divider (mean, then scaled
// level) and the 16-step square root are done, and later while the previous word is
// held by out_stall. Inside a frame a new pair is taken only after the last one has
// left S_SQ2; the output word register lets the next frame start while a result waits.
// Reset (synchronous, rst_n low): registers to defaults, sums, count and smoother cleared.
module smoothed_rms_audio_level_unit import srms_pkg::*; #(
  parameter int unsigned MAX_FRAME_PAIRS = MAX_FRAME_PAIRS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVEL_W-1:0]         out_rms_level,
  output logic [LEVEL_W-1:0]         out_smoothed_level,
  output logic [LEVEL_W-1:0]         out_scaled_level,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_PAIRS + 1);
  localparam int unsigned SUM_W = $clog2(MAX_FRAME_PAIRS) + 32;
  localparam int unsigned CMP_W = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
  localparam int unsigned DEN_W = (CNT_W + 1 > LEVEL_W) ? CNT_W + 1 : LEVEL_W;

  srms_state_t state_r, state_nxt;

  logic [FRAME_W-1:0] frame_pairs_r;
  logic [LEVEL_W-1:0] weight_r;
  logic [LEVEL_W-1:0] full_scale_r;

  logic signed [SAMPLE_W-1:0] right_r, right_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SMOOTH_W-1:0] smoother_r, smoother_nxt;
  logic [ROOT_W-1:0]   rms_r, rms_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [LEVEL_W-1:0]  scaled_r, scaled_nxt;
  logic [LEVEL_W-1:0]  out_rms_r, out_rms_nxt;
  logic [LEVEL_W-1:0]  out_smooth_r, out_smooth_nxt;
  logic [LEVEL_W-1:0]  out_scaled_r, out_scaled_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic             div_start;
  logic [SUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;

  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  logic [SUM_W-1:0]          sum_add;
  logic [CNT_W-1:0]          count_inc;
  logic [CMP_W-1:0]          n_eff;
  logic                      frame_end;
  logic [MUL_B_W-2:0]        weight_comp;
  logic [ACC_W-1:0]          smooth_sum;
  logic [SMOOTH_W+15:0]      scl_prod;
  logic [LEVEL_W-1:0]        fs_eff;

  srms_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  srms_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  srms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (div_quo[RAD_W-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    sum_add   = sum_r + SUM_W'(prod[31:0]);
    count_inc = count_r + CNT_W'(1);
    if (frame_pairs_r == '0) begin
      n_eff = CMP_W'(1);
    end else if (CMP_W'(frame_pairs_r) > CMP_W'(MAX_FRAME_PAIRS)) begin
      n_eff = CMP_W'(MAX_FRAME_PAIRS);
    end else begin
      n_eff = CMP_W'(frame_pairs_r);
    end
    frame_end   = CMP_W'(count_inc) >= n_eff;
    weight_comp = (MUL_B_W-1)'(17'h10000 - {1'b0, weight_r});
    smooth_sum  = acc_r + {prod[ACC_W-9:0], 8'h00};
    scl_prod    = {smoother_r, 16'h0000} - {16'h0000, smoother_r};
    fs_eff      = (full_scale_r == '0) ? LEVEL_W'(1) : full_scale_r;
  end

  always_comb begin
    state_nxt      = state_r;
    right_nxt      = right_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    smoother_nxt   = smoother_r;
    rms_nxt        = rms_r;
    acc_nxt        = acc_r;
    scaled_nxt     = scaled_r;
    out_rms_nxt    = out_rms_r;
    out_smooth_nxt = out_smooth_r;
    out_scaled_nxt = out_scaled_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_num        = '0;
    div_den        = '0;
    sqrt_start     = 1'b0;
    in_stall       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        mul_a    = MUL_A_W'(in_left_sample);
        mul_b    = MUL_B_W'(in_left_sample);
        if (in_valid) begin
          right_nxt = in_right_sample;
          state_nxt = S_SQ1;
        end
      end
      S_SQ1: begin
        mul_a     = MUL_A_W'(right_r);
        mul_b     = MUL_B_W'(right_r);
        sum_nxt   = sum_add;
        state_nxt = S_SQ2;
      end
      S_SQ2: begin
        if (frame_end) begin
          div_start = 1'b1;
          div_num   = sum_add;
          div_den   = DEN_W'({count_inc, 1'b0});
          sum_nxt   = '0;
          count_nxt = '0;
          state_nxt = S_DIV;
        end else begin
          sum_nxt   = sum_add;
          count_nxt = count_inc;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          rms_nxt   = sqrt_root;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        mul_a     = MUL_A_W'(smoother_r);
        mul_b     = MUL_B_W'(weight_comp);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        acc_nxt   = prod[ACC_W-1:0] + ROUND_HALF;
        mul_a     = MUL_A_W'(rms_r);
        mul_b     = MUL_B_W'(weight_r);
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        smoother_nxt = smooth_sum[SMOOTH_W+15:16];
        state_nxt    = S_SCL0;
      end
      S_SCL0: begin
        div_start = 1'b1;
        div_num   = SUM_W'(scl_prod[SMOOTH_W+15:8]);
        div_den   = DEN_W'(fs_eff);
        state_nxt = S_SCL;
      end
      S_SCL: begin
        if (div_done) begin
          scaled_nxt = (|div_quo[SUM_W-1:LEVEL_W]) ? '1 : div_quo[LEVEL_W-1:0];
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_rms_nxt    = rms_r;
          out_smooth_nxt = smoother_r[SMOOTH_W-1:8];
          out_scaled_nxt = scaled_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sum_r         <= '0;
      count_r       <= '0;
      smoother_r    <= '0;
      out_valid_r   <= 1'b0;
      frame_pairs_r <= FRAME_PAIRS_RST;
      weight_r      <= WEIGHT_RST;
      full_scale_r  <= FULL_SCALE_RST;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      smoother_r  <= smoother_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_PAIRS:   frame_pairs_r <= cfg_data[FRAME_W-1:0];
          REG_SMOOTH_WEIGHT: weight_r      <= cfg_data[LEVEL_W-1:0];
          REG_FULL_SCALE:    full_scale_r  <= cfg_data[LEVEL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    right_r      <= right_nxt;
    rms_r        <= rms_nxt;
    acc_r        <= acc_nxt;
    scaled_r     <= scaled_nxt;
    out_rms_r    <= out_rms_nxt;
    out_smooth_r <= out_smooth_nxt;
    out_scaled_r <= out_scaled_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_rms_level      = out_rms_r;
  assign out_smoothed_level = out_smooth_r;
  assign out_scaled_level   = out_scaled_r;

endmodule

// ===== rtl/srms_mul.sv =====
module srms_mul import srms_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/srms_div.sv =====
module srms_div #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = diff[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/srms_sqrt.sv =====
module srms_sqrt import srms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 4;

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;

  always_comb begin
    rem_shift = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial     = {2'b00, root_r, 2'b01};
    if (rem_shift >= trial) begin
      rem_nxt  = rem_shift - trial;
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_shift;
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/srms_chk.sv =====
module srms_chk import srms_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LEVEL_W-1:0] out_rms_level,
  input logic [LEVEL_W-1:0] out_smoothed_level,
  input logic [LEVEL_W-1:0] out_scaled_level
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rms_level)
      && $stable(out_smoothed_level) && $stable(out_scaled_level))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rms_level <= 16'd32768)
    else $error("rms level above full range");

endmodule

bind smoothed_rms_audio_level_unit srms_chk u_srms_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_rms_level      (out_rms_level),
  .out_smoothed_level (out_smoothed_level),
  .out_scaled_level   (out_scaled_level)
);
